>>> design/pairwise_distance_sorter_core_assert.svh
// Assertion helpers shared by the sorter RTL.
`ifndef PAIRWISE_DISTANCE_SORTER_CORE_ASSERT_SVH
`define PAIRWISE_DISTANCE_SORTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define PDS_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("pds assertion failed");

// Next-cycle implication, disabled while reset is low.
`define PDS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("pds assertion failed");

`endif

>>> design/pds_pkg.sv
`default_nettype none
package pds_pkg;
  localparam int MAX_POINTS_DEF = 8;
  localparam int COORD_W        = 16;
  localparam int DIST_W         = 24;
  localparam int KEY_W          = 34;
  localparam int SCALE          = 10000;
  localparam int SQ_IN_W        = 48;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDA,
    ST_RDB,
    ST_LDB,
    ST_MUL,
    ST_SCAN,
    ST_IDX,
    ST_PA,
    ST_PB,
    ST_ROOT,
    ST_WAIT,
    ST_OUT
  } state_t;
endpackage
`default_nettype wire

>>> design/pairwise_distance_sorter_core.sv
// Pairwise distance sorter. Points stream in one per cycle (in_ready high)
// until a point with in_last_point set; points beyond MAX_POINTS are dropped.
// The block then computes the squared distance of every pair i<j using one
// shared 16x16 multiplier, and emits pairs in descending
// distance order (ties in i-major creation order) with the distance rounded
// to hundredths. Each result is picked by a scan over the P stored pair keys,
// then fetches both points, runs a bit-serial square root and holds the
// result until it is taken; in_ready stays low until the final result,
// flagged by out_last_pair, is transferred.
`default_nettype none
`include "pairwise_distance_sorter_core_assert.svh"
module pairwise_distance_sorter_core #(
  parameter int MAX_POINTS = pds_pkg::MAX_POINTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [pds_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [pds_pkg::COORD_W-1:0] in_coord_y,
  input  logic signed [pds_pkg::COORD_W-1:0] in_coord_z,
  input  logic                              in_last_point,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [pds_pkg::COORD_W-1:0] out_first_x,
  output logic signed [pds_pkg::COORD_W-1:0] out_first_y,
  output logic signed [pds_pkg::COORD_W-1:0] out_first_z,
  output logic signed [pds_pkg::COORD_W-1:0] out_second_x,
  output logic signed [pds_pkg::COORD_W-1:0] out_second_y,
  output logic signed [pds_pkg::COORD_W-1:0] out_second_z,
  output logic [pds_pkg::DIST_W-1:0]         out_dist_hundredths,
  output logic                              out_last_pair
);
  import pds_pkg::*;

  localparam int PW     = $clog2(MAX_POINTS);
  localparam int CW     = $clog2(MAX_POINTS + 1);
  localparam int NPAIRS = MAX_POINTS * (MAX_POINTS - 1) / 2;
  localparam int SW     = $clog2(NPAIRS + 1);
  localparam int PIW    = (NPAIRS > 1) ? $clog2(NPAIRS) : 1;
  localparam int PT_W   = 3 * COORD_W;

  state_t state_r, state_nxt;

  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     n_r;
  logic [PW-1:0]     i_r, j_r;
  logic [SW-1:0]     p_r;
  logic [1:0]        k_r;
  logic [PT_W-1:0]   pa_r, pb_r;
  logic [KEY_W-1:0]  acc_r;
  logic [SW-1:0]     s_r;
  logic [PIW-1:0]    best_r;
  logic [KEY_W-1:0]  best_key_r;
  logic              found_r;
  logic [NPAIRS-1:0] done_r;
  logic [SW-1:0]     emit_r;

  logic [PT_W-1:0]   pmem [MAX_POINTS];
  logic [PT_W-1:0]   prd_r;
  logic [PW-1:0]     paddr;
  logic [KEY_W-1:0]  kmem [NPAIRS];
  logic [KEY_W-1:0]  krd_r;
  logic [2*PW-1:0]   imem [NPAIRS];
  logic [2*PW-1:0]   ird_r;

  logic [PT_W-1:0]   first_r, second_r;
  logic [DIST_W-1:0] dist_r;
  logic              last_r;

  logic              in_xfer, out_xfer;
  logic              full;
  logic [CW-1:0]     n_eff;
  logic              gen_end, row_end;
  logic [COORD_W-1:0] ca, cb;
  logic [COORD_W:0]  diff;
  logic [COORD_W-1:0] mag;
  logic [2*COORD_W-1:0] sq;
  logic [KEY_W-1:0]  acc_sum;
  logic [PIW-1:0]    cidx;
  logic              cand;
  logic              scan_end;
  logic              sq_start, sq_done;
  logic [DIST_W-1:0] sq_root;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign full     = cnt_r == CW'(MAX_POINTS);
  assign n_eff    = full ? cnt_r : cnt_r + CW'(1);
  assign row_end  = j_r == PW'(n_r - CW'(1));
  assign gen_end  = row_end && ((CW'(i_r) + CW'(2)) == n_r);
  assign scan_end = s_r == p_r;

  // Shared squarer: one coordinate per cycle
  always_comb begin
    unique case (k_r)
      2'd0:    begin ca = pa_r[3*COORD_W-1 -: COORD_W]; cb = pb_r[3*COORD_W-1 -: COORD_W]; end
      2'd1:    begin ca = pa_r[2*COORD_W-1 -: COORD_W]; cb = pb_r[2*COORD_W-1 -: COORD_W]; end
      default: begin ca = pa_r[COORD_W-1:0];            cb = pb_r[COORD_W-1:0];            end
    endcase
  end
  assign diff    = {ca[COORD_W-1], ca} - {cb[COORD_W-1], cb};
  assign mag     = diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];
  assign sq      = mag * mag;
  assign acc_sum = ((k_r == 2'd0) ? '0 : acc_r) + KEY_W'(sq);

  // Max search candidate for the key read last cycle
  assign cidx = PIW'(s_r - SW'(1));
  assign cand = (s_r != '0) && !done_r[cidx] && (!found_r || (krd_r > best_key_r));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_xfer && in_last_point && (n_eff >= CW'(2))) state_nxt = ST_RDA;
      ST_RDA:  state_nxt = ST_RDB;
      ST_RDB:  state_nxt = ST_LDB;
      ST_LDB:  state_nxt = ST_MUL;
      ST_MUL:  if (k_r == 2'd2) state_nxt = gen_end ? ST_SCAN : ST_RDA;
      ST_SCAN: if (scan_end) state_nxt = ST_IDX;
      ST_IDX:  state_nxt = ST_PA;
      ST_PA:   state_nxt = ST_PB;
      ST_PB:   state_nxt = ST_ROOT;
      ST_ROOT: state_nxt = ST_WAIT;
      ST_WAIT: if (sq_done) state_nxt = ST_OUT;
      ST_OUT:  if (out_ready) state_nxt = last_r ? ST_IDLE : ST_SCAN;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs and point read address
  always_comb begin
    in_ready  = state_r == ST_IDLE;
    out_valid = state_r == ST_OUT;
    sq_start  = state_r == ST_ROOT;
    unique case (state_r)
      ST_RDA:  paddr = i_r;
      ST_RDB:  paddr = j_r;
      ST_PA:   paddr = ird_r[2*PW-1:PW];
      default: paddr = ird_r[PW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer) begin
        cnt_r <= in_last_point ? '0 : n_eff;
      end
    end
  end

  // Point store
  always_ff @(posedge clk) begin
    if (in_xfer && !full) begin
      pmem[cnt_r[PW-1:0]] <= {in_coord_x, in_coord_y, in_coord_z};
    end
    prd_r <= pmem[paddr];
  end

  // Pair key and index store
  always_ff @(posedge clk) begin
    if ((state_r == ST_MUL) && (k_r == 2'd2)) begin
      kmem[p_r[PIW-1:0]] <= acc_sum;
      imem[p_r[PIW-1:0]] <= {i_r, j_r};
    end
    if ((state_r == ST_SCAN) && !scan_end) begin
      krd_r <= kmem[s_r[PIW-1:0]];
    end
    ird_r <= imem[best_r];
  end

  // Datapath sequencing
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        n_r    <= n_eff;
        i_r    <= '0;
        j_r    <= PW'(1);
        p_r    <= '0;
        emit_r <= '0;
        s_r    <= '0;
        found_r <= 1'b0;
        done_r <= '0;
      end
      ST_RDB: pa_r <= prd_r;
      ST_LDB: begin
        pb_r <= prd_r;
        k_r  <= 2'd0;
      end
      ST_MUL: begin
        acc_r <= acc_sum;
        k_r   <= k_r + 2'd1;
        if (k_r == 2'd2) begin
          p_r <= p_r + SW'(1);
          if (row_end) begin
            i_r <= i_r + PW'(1);
            j_r <= i_r + PW'(2);
          end else begin
            j_r <= j_r + PW'(1);
          end
        end
      end
      ST_SCAN: begin
        if (cand) begin
          best_r     <= cidx;
          best_key_r <= krd_r;
          found_r    <= 1'b1;
        end
        if (!scan_end) s_r <= s_r + SW'(1);
      end
      ST_IDX: done_r[best_r] <= 1'b1;
      ST_PB:  first_r <= prd_r;
      ST_ROOT: begin
        second_r <= prd_r;
        last_r   <= (emit_r + SW'(1)) == p_r;
      end
      ST_WAIT: if (sq_done) dist_r <= sq_root;
      ST_OUT: begin
        if (out_ready) begin
          emit_r  <= emit_r + SW'(1);
          s_r     <= '0;
          found_r <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Rounded root of the scaled squared distance
  pds_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .value (SQ_IN_W'(best_key_r) * SQ_IN_W'(SCALE)),
    .done  (sq_done),
    .root  (sq_root)
  );

  assign out_first_x         = first_r[3*COORD_W-1 -: COORD_W];
  assign out_first_y         = first_r[2*COORD_W-1 -: COORD_W];
  assign out_first_z         = first_r[COORD_W-1:0];
  assign out_second_x        = second_r[3*COORD_W-1 -: COORD_W];
  assign out_second_y        = second_r[2*COORD_W-1 -: COORD_W];
  assign out_second_z        = second_r[COORD_W-1:0];
  assign out_dist_hundredths = dist_r;
  assign out_last_pair       = last_r;

  `PDS_ASSERT_IMPL(a_out_blocks_in, clk, rst_n, out_valid, !in_ready)
  `PDS_ASSERT_IMPL(a_cnt_range, clk, rst_n, state_r == ST_IDLE, cnt_r <= CW'(MAX_POINTS))
  `PDS_ASSERT_IMPL(a_emit_range, clk, rst_n, out_valid, emit_r < p_r)
  `PDS_ASSERT_NEXT(a_last_frees, clk, rst_n, out_valid && out_ready && out_last_pair, in_ready)
endmodule
`default_nettype wire

>>> design/pds_sqrt.sv
`default_nettype none
module pds_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pds_pkg::SQ_IN_W-1:0] value,
  output logic                        done,
  output logic [pds_pkg::DIST_W-1:0]  root
);
  import pds_pkg::*;

  localparam int STEPS  = SQ_IN_W / 2;
  localparam int STEP_W = $clog2(STEPS);
  localparam int RW     = DIST_W + 2;

  logic [SQ_IN_W-1:0] val_r;
  logic [RW-1:0]      rem_r;
  logic [DIST_W-1:0]  root_r;
  logic [STEP_W-1:0]  cnt_r;
  logic               run_r;
  logic               fin_r;
  logic               done_r;
  logic [RW-1:0]      rem_sh;
  logic [RW-1:0]      trial;
  logic               ge;

  // One result bit per cycle, restoring digit recurrence
  assign rem_sh = {rem_r[RW-3:0], val_r[SQ_IN_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= fin_r;
      fin_r  <= run_r && (cnt_r == STEP_W'(STEPS - 1));
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && (cnt_r == STEP_W'(STEPS - 1))) begin
        run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_r  <= value;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '0;
    end else if (run_r) begin
      val_r <= {val_r[SQ_IN_W-3:0], 2'b00};
      cnt_r <= cnt_r + STEP_W'(1);
      if (ge) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[DIST_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[DIST_W-2:0], 1'b0};
      end
    end else if (fin_r) begin
      // round to nearest: remainder above root means past the half step
      if (rem_r > RW'(root_r)) begin
        root_r <= root_r + DIST_W'(1);
      end
    end
  end

  assign done = done_r;
  assign root = root_r;
endmodule
`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import pds_pkg::*;

  localparam int NPTS = MAX_POINTS_DEF;
  localparam int CYCLE_LIMIT = 900000;

  typedef struct {
    logic signed [COORD_W-1:0] ax, ay, az, bx, by, bz;
    logic [DIST_W-1:0]         hund;
    logic                      last;
  } pair_res_t;

  typedef struct {
    logic signed [COORD_W-1:0] x, y, z;
    logic                      last;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COORD_W-1:0] in_coord_x = '0, in_coord_y = '0, in_coord_z = '0;
  logic in_last_point = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [COORD_W-1:0] out_first_x, out_first_y, out_first_z;
  logic signed [COORD_W-1:0] out_second_x, out_second_y, out_second_z;
  logic [DIST_W-1:0] out_dist_hundredths;
  logic out_last_pair;

  pairwise_distance_sorter_core uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  point_t    held_pts[NPTS];
  int unsigned held_cnt = 0;
  pair_res_t pending_pairs[$];
  int        err_cnt = 0;
  int        send_idle = 25, recv_idle = 87;
  longint unsigned cycle_cnt = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_cnt);
    err_cnt++;
  endtask

  function automatic longint unsigned round_root(input longint unsigned n);
    longint unsigned r, bitv, res;
    r = n; res = 0; bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (r >= res + bitv) begin
        r -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    if (r > res) res++;
    return res;
  endfunction

  // store a point; on the final one sort all pairs by distance, stable descending
  task automatic predict_point(input point_t p);
    longint unsigned keys[$];
    int ia[$], ib[$];
    longint signed d;
    longint unsigned s, tk;
    int t, n;
    pair_res_t r;
    if (held_cnt < NPTS) begin
      held_pts[held_cnt] = p;
      held_cnt++;
    end
    if (!p.last) return;
    n = held_cnt;
    held_cnt = 0;
    for (int i = 0; i < n; i++)
      for (int j = i + 1; j < n; j++) begin
        d = held_pts[i].x - held_pts[j].x; s = d * d;
        d = held_pts[i].y - held_pts[j].y; s += d * d;
        d = held_pts[i].z - held_pts[j].z; s += d * d;
        keys.push_back(s); ia.push_back(i); ib.push_back(j);
      end
    for (int i = 0; i < keys.size(); i++)
      for (int j = keys.size() - 1; j > i; j--)
        if (keys[j] > keys[j-1]) begin
          tk = keys[j]; keys[j] = keys[j-1]; keys[j-1] = tk;
          t = ia[j]; ia[j] = ia[j-1]; ia[j-1] = t;
          t = ib[j]; ib[j] = ib[j-1]; ib[j-1] = t;
        end
    for (int i = 0; i < keys.size(); i++) begin
      r.ax = held_pts[ia[i]].x; r.ay = held_pts[ia[i]].y; r.az = held_pts[ia[i]].z;
      r.bx = held_pts[ib[i]].x; r.by = held_pts[ib[i]].y; r.bz = held_pts[ib[i]].z;
      r.hund = DIST_W'(round_root(keys[i] * 10000));
      r.last = (i + 1 == keys.size());
      pending_pairs.push_back(r);
    end
  endtask

  // send one point; waits for its transfer, valid drops only when idling
  task automatic send_point(input point_t p);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_coord_x <= p.x; in_coord_y <= p.y; in_coord_z <= p.z;
    in_last_point <= p.last;
    do @(posedge clk); while (!in_ready);
    predict_point(p);
  endtask

  // receiver: random stall, check each transfer against oldest expectation
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_pairs.size() == 0) begin
          report_mismatch("unexpected pair", out_dist_hundredths, -1);
        end else begin
          pair_res_t e;
          e = pending_pairs.pop_front();
          if (out_first_x !== e.ax) report_mismatch("first_x", out_first_x, e.ax);
          if (out_first_y !== e.ay) report_mismatch("first_y", out_first_y, e.ay);
          if (out_first_z !== e.az) report_mismatch("first_z", out_first_z, e.az);
          if (out_second_x !== e.bx) report_mismatch("second_x", out_second_x, e.bx);
          if (out_second_y !== e.by) report_mismatch("second_y", out_second_y, e.by);
          if (out_second_z !== e.bz) report_mismatch("second_z", out_second_z, e.bz);
          if (out_dist_hundredths !== e.hund)
            report_mismatch("dist_hundredths", out_dist_hundredths, e.hund);
          if (out_last_pair !== e.last) report_mismatch("last_pair", out_last_pair, e.last);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic point_t rand_point(input bit last, input int spread);
    point_t p;
    if (spread == 0) begin
      p.x = COORD_W'($urandom); p.y = COORD_W'($urandom); p.z = COORD_W'($urandom);
    end else begin
      p.x = COORD_W'($urandom_range(2 * spread) - spread);
      p.y = COORD_W'($urandom_range(2 * spread) - spread);
      p.z = COORD_W'($urandom_range(2 * spread) - spread);
    end
    p.last = last;
    return p;
  endfunction

  // directed points: extremes, ties, lone point, store overflow
  localparam int NDIR = 22;
  point_t dir_tab[NDIR] = '{
    '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0},
    '{16'sd32767, 16'sd32767, 16'sd32767, 1'b1},    // max distance 11350995
    '{16'sd5, 16'sd5, 16'sd5, 1'b1},                // lone point: nothing
    '{16'sd0, 16'sd0, 16'sd0, 1'b0},
    '{16'sd1, 16'sd0, 16'sd0, 1'b0},
    '{16'sd0, 16'sd1, 16'sd0, 1'b0},
    '{16'sd0, 16'sd0, 16'sd1, 1'b1},                // ties keep creation order
    '{16'sd7, -16'sd7, 16'sd7, 1'b0},
    '{16'sd7, -16'sd7, 16'sd7, 1'b1},               // zero distance
    '{16'sd0, 16'sd0, 16'sd0, 1'b0},
    '{16'sd1, 16'sd1, 16'sd0, 1'b0},
    '{-16'sd1, 16'sd0, 16'sd0, 1'b0},
    '{16'sd3, 16'sd4, 16'sd0, 1'b0},
    '{-16'sd32768, 16'sd32767, 16'sd0, 1'b0},
    '{16'sd100, -16'sd200, 16'sd300, 1'b0},
    '{16'sd2, 16'sd2, 16'sd1, 1'b0},
    '{-16'sd5, 16'sd12, 16'sd0, 1'b0},
    '{16'sd9, 16'sd9, 16'sd9, 1'b0},                // dropped: store full
    '{16'sd8, 16'sd8, 16'sd8, 1'b1},                // dropped, still ends the set
    '{16'sd0, 16'sd0, 16'sd0, 1'b0},
    '{16'sd0, 16'sd0, 16'sd1, 1'b1},                // distance 100
    '{16'sd0, 16'sd0, 16'sd0, 1'b1}                 // lone point again
  };

  initial begin
    int sent, setsz, spread;
    point_t p;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // known results off the directed table
    pending_pairs.delete();
    for (int i = 0; i < NDIR; i++) send_point(dir_tab[i]);
    sent = NDIR;
    // random sets, three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle = 87; recv_idle = 25; end
      if (ph == 2) begin send_idle = 0; recv_idle = 0; end
      while (sent < NDIR + (ph + 1) * 90) begin
        setsz = ($urandom_range(9) == 0) ? NPTS + $urandom_range(1, 3)
                                        : $urandom_range(1, 5);
        case ($urandom_range(2))
          0: spread = 0;
          1: spread = 4;
          default: spread = 3000;
        endcase
        for (int k = 0; k < setsz; k++) begin
          p = rand_point(k == setsz - 1, spread);
          send_point(p);
          sent++;
        end
      end
    end
    in_valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (err_cnt == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
+incdir+design
design/pds_pkg.sv
design/pds_sqrt.sv
design/pairwise_distance_sorter_core.sv
dv/tb_top.sv
